// ===== rtl/core/ppmd_pkg.sv =====
// Shared types and constants for the PPM frame decoder.
// Used by the controller, the datapath, the top level and the port checker.
package ppmd_pkg;

  // Largest number of channels that one frame may carry.
  localparam int unsigned MAX_CHANNELS = 16;

  // Register reset values.
  localparam logic [15:0] SYNC_THRESHOLD_RST = 16'd3990;
  localparam logic [15:0] MIN_PULSE_RST      = 16'd900;
  localparam logic [15:0] MAX_PULSE_RST      = 16'd2100;
  localparam logic [31:0] LOSS_TIMEOUT_RST   = 32'd60000;
  localparam logic [4:0]  MIN_CHANNELS_RST   = 5'd4;

  // Largest value that fits in a channel value field.
  localparam logic [11:0] CHANNEL_VALUE_MAX = 12'hFFF;

  // Item kinds on the input channel.
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SYNC_THRESHOLD = 3'd0,
    REG_MIN_PULSE      = 3'd1,
    REG_MAX_PULSE      = 3'd2,
    REG_LOSS_TIMEOUT   = 3'd3,
    REG_MIN_CHANNELS   = 3'd4
  } ppmd_reg_t;

  // Result kinds on the output channel.
  typedef enum logic [1:0] {
    RK_CHANNEL  = 2'd0,
    RK_LOST     = 2'd1,
    RK_RESTORED = 2'd2
  } ppmd_rkind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // register the accepted request
    logic sync;      // close the frame and start the channel run
    logic store;     // buffer one channel interval
    logic abort;     // drop the frame until the next sync
    logic lose;      // mark the signal as lost
    logic restore;   // mark the signal as restored
    logic emit;      // load the next channel into the output register
    logic note;      // load a loss or restore result into the output register
  } ppmd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_poll;
    logic is_sync;
    logic chan_ok;
    logic timed_out;
    logic lost;
    logic restore_ok;
    logic frame_empty;
    logic emit_last;
    logic out_free;
  } ppmd_sts_t;

endpackage

// ===== rtl/core/ppmd_ctrl.sv =====
// Controller of the PPM frame decoder: sequences accept, evaluation and result output.
// Depends on ppmd_pkg for the command and status structs.
module ppmd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppmd_pkg::ppmd_sts_t sts,
  output ppmd_pkg::ppmd_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_EMIT = 4'b0100,
    S_NOTE = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Requests are taken only while no evaluation or output run is in progress.
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        if (!sts.is_poll) begin
          if (sts.is_sync) begin
            cmd.sync = 1'b1;
            if (!sts.frame_empty) begin
              state_nxt = S_EMIT;
            end
          end else if (sts.chan_ok) begin
            cmd.store = 1'b1;
          end else begin
            cmd.abort = 1'b1;
          end
        end else if (sts.timed_out) begin
          if (!sts.lost) begin
            cmd.lose  = 1'b1;
            state_nxt = S_NOTE;
          end
        end else if (sts.lost && sts.restore_ok) begin
          cmd.restore = 1'b1;
          state_nxt   = S_NOTE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_NOTE: begin
        if (sts.out_free) begin
          cmd.note  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/ppmd_dpath.sv =====
// Datapath of the PPM frame decoder: registers, decode state, channel buffer, output register.
// Depends on ppmd_pkg for constants, codes and the command and status structs.
module ppmd_dpath (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration writes.
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  // Input payload.
  input  logic                in_kind,
  input  logic [31:0]         in_interval_us,
  input  logic [31:0]         in_now_us,
  // Output channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_result_kind,
  output logic [3:0]          out_channel_index,
  output logic [11:0]         out_channel_value,
  output logic [4:0]          out_channel_count,
  output logic                out_last,
  // Controller link.
  input  ppmd_pkg::ppmd_cmd_t cmd,
  output ppmd_pkg::ppmd_sts_t sts
);

  // Configuration registers.
  logic [15:0] sync_threshold_r;
  logic [15:0] min_pulse_r;
  logic [15:0] max_pulse_r;
  logic [31:0] loss_timeout_r;
  logic [4:0]  min_channels_r;

  // Captured request.
  logic        kind_r;
  logic [31:0] interval_r;
  logic [31:0] now_r;

  // Decode state.
  logic        in_frame_r,  in_frame_nxt;
  logic [4:0]  running_r,   running_nxt;
  logic [4:0]  latched_r,   latched_nxt;
  logic [31:0] last_sync_r, last_sync_nxt;
  logic        lost_r,      lost_nxt;

  // Channel run counters.
  logic [3:0]  emit_idx_r;
  logic [4:0]  emit_cnt_r;

  // Channel buffer.
  logic [11:0] chan_mem [ppmd_pkg::MAX_CHANNELS];

  // Output register.
  logic                  out_valid_r;
  ppmd_pkg::ppmd_rkind_t out_kind_r;
  logic [3:0]            out_index_r;
  logic [11:0]           out_value_r;
  logic [4:0]            out_count_r;
  logic                  out_last_r;

  logic [31:0] elapsed;
  logic [11:0] chan_sat;
  logic        out_free;
  logic        emit_last;

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_threshold_r <= ppmd_pkg::SYNC_THRESHOLD_RST;
      min_pulse_r      <= ppmd_pkg::MIN_PULSE_RST;
      max_pulse_r      <= ppmd_pkg::MAX_PULSE_RST;
      loss_timeout_r   <= ppmd_pkg::LOSS_TIMEOUT_RST;
      min_channels_r   <= ppmd_pkg::MIN_CHANNELS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ppmd_pkg::REG_SYNC_THRESHOLD: sync_threshold_r <= cfg_data[15:0];
        ppmd_pkg::REG_MIN_PULSE:      min_pulse_r      <= cfg_data[15:0];
        ppmd_pkg::REG_MAX_PULSE:      max_pulse_r      <= cfg_data[15:0];
        ppmd_pkg::REG_LOSS_TIMEOUT:   loss_timeout_r   <= cfg_data;
        ppmd_pkg::REG_MIN_CHANNELS:   min_channels_r   <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r     <= in_kind;
      interval_r <= in_interval_us;
      now_r      <= in_now_us;
    end
  end

  // Classification of the captured request.
  assign elapsed  = now_r - last_sync_r;
  assign chan_sat = (interval_r > {20'd0, ppmd_pkg::CHANNEL_VALUE_MAX}) ?
                    ppmd_pkg::CHANNEL_VALUE_MAX : interval_r[11:0];
  assign out_free = !out_valid_r || !out_stall;
  assign emit_last = (({1'b0, emit_idx_r} + 5'd1) == emit_cnt_r);

  always_comb begin
    sts             = '0;
    sts.is_poll     = (kind_r == ppmd_pkg::KIND_POLL);
    sts.is_sync     = (interval_r > {16'd0, sync_threshold_r});
    sts.chan_ok     = (interval_r > {16'd0, min_pulse_r}) &&
                      (interval_r < {16'd0, max_pulse_r}) &&
                      in_frame_r &&
                      (running_r < 5'(ppmd_pkg::MAX_CHANNELS));
    sts.timed_out   = (elapsed > loss_timeout_r);
    sts.lost        = lost_r;
    sts.restore_ok  = (latched_r >= min_channels_r) &&
                      (latched_r <= 5'(ppmd_pkg::MAX_CHANNELS));
    sts.frame_empty = (running_r == 5'd0);
    sts.emit_last   = emit_last;
    sts.out_free    = out_free;
  end

  // Frame and link state updates.
  always_comb begin
    in_frame_nxt  = in_frame_r;
    running_nxt   = running_r;
    latched_nxt   = latched_r;
    last_sync_nxt = last_sync_r;
    lost_nxt      = lost_r;
    if (cmd.sync) begin
      in_frame_nxt  = 1'b1;
      running_nxt   = 5'd0;
      latched_nxt   = running_r;
      last_sync_nxt = now_r;
    end
    if (cmd.store) begin
      running_nxt = running_r + 5'd1;
    end
    if (cmd.abort) begin
      in_frame_nxt = 1'b0;
      running_nxt  = 5'd0;
    end
    if (cmd.lose) begin
      lost_nxt    = 1'b1;
      latched_nxt = 5'd0;
    end
    if (cmd.restore) begin
      lost_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      running_r   <= 5'd0;
      latched_r   <= 5'd0;
      last_sync_r <= 32'd0;
      lost_r      <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      running_r   <= running_nxt;
      latched_r   <= latched_nxt;
      last_sync_r <= last_sync_nxt;
      lost_r      <= lost_nxt;
    end
  end

  // Channel buffer write; only entries below the running count are ever read.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      chan_mem[running_r[3:0]] <= chan_sat;
    end
  end

  // Run counters: the frame size is snapshot at sync, the index steps per emitted channel.
  always_ff @(posedge clk) begin
    if (cmd.sync) begin
      emit_idx_r <= 4'd0;
      emit_cnt_r <= running_r;
    end else if (cmd.emit) begin
      emit_idx_r <= emit_idx_r + 4'd1;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.note) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload. A note after a loss carries count zero, after a restore the latched count.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r  <= ppmd_pkg::RK_CHANNEL;
      out_index_r <= emit_idx_r;
      out_value_r <= chan_mem[emit_idx_r];
      out_count_r <= emit_cnt_r;
      out_last_r  <= emit_last;
    end else if (cmd.note) begin
      out_kind_r  <= lost_r ? ppmd_pkg::RK_LOST : ppmd_pkg::RK_RESTORED;
      out_index_r <= 4'd0;
      out_value_r <= 12'd0;
      out_count_r <= latched_r;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_channel_index = out_index_r;
  assign out_channel_value = out_value_r;
  assign out_channel_count = out_count_r;
  assign out_last          = out_last_r;

endmodule

// ===== rtl/core/ppm_frame_decoder.sv =====
// PPM frame decoder: takes no new request until it is done with the previous one. A poll that
// reports loss or restore loads one note, a sync edge emits its N buffered channels one per
// cycle while the output is not stalled; each result waits until the output register is free.
// The single output register sets the emit pace. Synchronous active-low reset restores
// register defaults, clears frame, count, sync time and loss state; the buffer is not cleared.
// Top level: joins the controller (ppmd_ctrl) and the datapath (ppmd_dpath); uses ppmd_pkg.
module ppm_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Input request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_interval_us,
  input  logic [31:0] in_now_us,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [3:0]  out_channel_index,
  output logic [11:0] out_channel_value,
  output logic [4:0]  out_channel_count,
  output logic        out_last
);

  ppmd_pkg::ppmd_cmd_t cmd;
  ppmd_pkg::ppmd_sts_t sts;

  // Register writes are taken in every cycle.
  assign cfg_ready = 1'b1;

  ppmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppmd_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_kind           (in_kind),
    .in_interval_us    (in_interval_us),
    .in_now_us         (in_now_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_channel_count (out_channel_count),
    .out_last          (out_last),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

// ===== rtl/core/ppmd_chk.sv =====
// Port checker for the PPM frame decoder, bound to the top level.
// Depends on ppmd_pkg for the result kind codes.
module ppmd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_result_kind,
  input logic [3:0]  out_channel_index,
  input logic [11:0] out_channel_value,
  input logic [4:0]  out_channel_count,
  input logic        out_last
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_channel_index) && $stable(out_channel_value) &&
      $stable(out_channel_count) && $stable(out_last))
    else $error("stalled result changed");

  // Loss and restore results are single-item runs with zero index and value.
  a_note_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != ppmd_pkg::RK_CHANNEL |->
      out_last && out_channel_index == 4'd0 && out_channel_value == 12'd0)
    else $error("malformed loss or restore result");

  // A loss result always reports a cleared channel count.
  a_lost_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == ppmd_pkg::RK_LOST |-> out_channel_count == 5'd0)
    else $error("loss result with nonzero count");

  // The decoder is busy evaluating in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken in the evaluation cycle");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ppm_frame_decoder ppmd_chk u_ppmd_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_result_kind   (out_result_kind),
  .out_channel_index (out_channel_index),
  .out_channel_value (out_channel_value),
  .out_channel_count (out_channel_count),
  .out_last          (out_last)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for ppm_frame_decoder: a directed table of frames, losses and restores,
// then random pulse trains over several register settings, checked by a behavioral decoder.
// Depends on ppmd_pkg and the RTL of ppm_frame_decoder.
module tb;
  import ppmd_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BLOCK_ITEMS    = 68;
  localparam int NUM_BLOCKS     = 6;
  localparam int PRESSURE_BLOCK = 4;
  localparam int FIRST_STAMP    = 90000;

  // Register indexes that decode to nothing.
  localparam logic [2:0] SPARE_INDEX_LO = 3'd5;
  localparam logic [2:0] SPARE_INDEX_HI = 3'd7;

  // One result as the block reports it.
  typedef struct packed {
    ppmd_rkind_t rkind;
    logic [3:0]  idx;
    logic [11:0] val;
    logic [4:0]  cnt;
    logic        last;
  } ppm_result_t;

  // How a row of the directed table is checked.
  typedef enum logic [1:0] {
    BY_DECODER = 2'd0,
    NO_RESULT  = 2'd1,
    ONE_RESULT = 2'd2
  } row_check_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] ivl;
    logic [31:0] now;
    row_check_t  check;
    ppm_result_t res;
  } stim_row_t;

  typedef struct packed {
    logic [15:0] thr;
    logic [15:0] minp;
    logic [15:0] maxp;
    logic [31:0] tmo;
    logic [4:0]  minch;
  } reg_set_t;

  localparam ppm_result_t NO_RES = '0;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [31:0] in_interval_us;
  logic [31:0] in_now_us;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_kind;
  logic [3:0]  out_channel_index;
  logic [11:0] out_channel_value;
  logic [4:0]  out_channel_count;
  logic        out_last;

  // Register shadows and decoder state.
  logic [15:0] sync_thr_q;
  logic [15:0] min_pulse_q;
  logic [15:0] max_pulse_q;
  logic [31:0] loss_tmo_q;
  logic [4:0]  min_chan_q;
  logic        frame_open;
  logic [4:0]  run_count;
  logic [11:0] chan_buf [MAX_CHANNELS];
  logic [4:0]  held_count;
  logic [31:0] sync_stamp;
  logic        lost_flag;

  ppm_result_t ppm_results_due [$];
  logic [31:0] clock_us;
  int          in_gap_pct;
  int          out_gap_pct;
  int          bad_fields = 0;
  int          quiet_cycles = 0;
  bit          hold_pending = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  ppm_frame_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_interval_us    (in_interval_us),
    .in_now_us         (in_now_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_channel_count (out_channel_count),
    .out_last          (out_last)
  );

  // Decode one accepted request, optionally queueing the results it causes.
  function automatic void decode_ppm_item(input logic kind, input logic [31:0] ivl,
                                          input logic [31:0] now, input bit queue_results);
    ppm_result_t r;
    logic [31:0] elapsed;
    int          i;
    r = '0;
    if (kind == KIND_EDGE) begin
      if (ivl > sync_thr_q) begin
        // Frame sync: flush the buffered channels as one run.
        for (i = 0; i < run_count; i++) begin
          r.rkind = RK_CHANNEL;
          r.idx   = i[3:0];
          r.val   = chan_buf[i];
          r.cnt   = run_count;
          r.last  = (i + 1 == run_count);
          if (queue_results) ppm_results_due.push_back(r);
        end
        held_count = run_count;
        run_count  = '0;
        frame_open = 1'b1;
        sync_stamp = now;
      end else if (ivl > min_pulse_q && ivl < max_pulse_q && frame_open &&
                   run_count < MAX_CHANNELS) begin
        chan_buf[run_count] = (ivl > 32'(CHANNEL_VALUE_MAX)) ? CHANNEL_VALUE_MAX : ivl[11:0];
        run_count++;
      end else begin
        run_count  = '0;
        frame_open = 1'b0;
      end
    end else begin
      // Status poll: loss is reported once, restoration once per loss.
      elapsed = now - sync_stamp;
      r.last  = 1'b1;
      if (elapsed > loss_tmo_q) begin
        if (!lost_flag) begin
          lost_flag  = 1'b1;
          held_count = '0;
          r.rkind    = RK_LOST;
          if (queue_results) ppm_results_due.push_back(r);
        end
      end else if (lost_flag && held_count >= min_chan_q && held_count <= MAX_CHANNELS) begin
        lost_flag = 1'b0;
        r.rkind   = RK_RESTORED;
        r.cnt     = held_count;
        if (queue_results) ppm_results_due.push_back(r);
      end
    end
  endfunction

  // An interval that the current settings buffer as a channel, where one exists.
  function automatic logic [31:0] pick_channel();
    int lo;
    int hi;
    lo = int'(min_pulse_q) + 1;
    hi = int'(max_pulse_q) - 1;
    if (hi >= lo) return $urandom_range(hi, lo);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_sync();
    if ($urandom_range(7) == 0) return 32'hFFFF_FFFF;
    return sync_thr_q + 32'd1 + $urandom_range(50000);
  endfunction

  task automatic flag_result(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    bad_fields++;
  endtask

  // Offer one request, with random idle cycles ahead of it, and wait for acceptance.
  task automatic offer_request(input logic kind, input logic [31:0] ivl,
                               input logic [31:0] now, input bit queue_results);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_interval_us <= ivl;
    in_now_us      <= now;
    do @(posedge clk); while (in_stall);
    decode_ppm_item(kind, ivl, now, queue_results);
  endtask

  // Edges carry timestamps that advance by their own interval.
  task automatic send_edge(input logic [31:0] ivl);
    clock_us += ivl;
    offer_request(KIND_EDGE, ivl, clock_us, 1'b1);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SYNC_THRESHOLD: sync_thr_q  = val[15:0];
      REG_MIN_PULSE:      min_pulse_q = val[15:0];
      REG_MAX_PULSE:      max_pulse_q = val[15:0];
      REG_LOSS_TIMEOUT:   loss_tmo_q  = val;
      REG_MIN_CHANNELS:   min_chan_q  = val[4:0];
      default: ;
    endcase
  endtask

  // Upper bits of narrow registers carry noise that the block must drop.
  task automatic program_regs(input reg_set_t s);
    write_reg(REG_SYNC_THRESHOLD, {16'($urandom), s.thr});
    write_reg(REG_MIN_PULSE, {16'($urandom), s.minp});
    write_reg(REG_MAX_PULSE, {16'($urandom), s.maxp});
    write_reg(REG_LOSS_TIMEOUT, s.tmo);
    write_reg(REG_MIN_CHANNELS, {27'($urandom), s.minch});
    write_reg(3'($urandom_range(SPARE_INDEX_HI, SPARE_INDEX_LO)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every predicted result, then let in-flight requests settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (ppm_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames, plus polls, out-of-range edges and random noise.
  task automatic run_random_block(input int quota);
    int done_items;
    int sel;
    int n;
    int k;
    done_items = 0;
    while (done_items < quota) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        if (!frame_open) begin
          send_edge(pick_sync());
          done_items++;
        end
        n = ($urandom_range(9) == 0) ? int'($urandom_range(17, 16)) : int'($urandom_range(6));
        for (k = 0; k < n; k++) send_edge(pick_channel());
        send_edge(pick_sync());
        done_items += n + 1;
      end else if (sel < 75) begin
        if ($urandom_range(3) == 0) clock_us += loss_tmo_q + 32'd1 + $urandom_range(5000);
        else clock_us += $urandom_range(2000);
        offer_request(KIND_POLL, $urandom, clock_us, 1'b1);
        done_items++;
      end else if (sel < 90) begin
        offer_request(KIND_EDGE, $urandom_range(1) ? $urandom : $urandom_range(5000),
                      $urandom, 1'b1);
        done_items++;
      end else begin
        offer_request(KIND_POLL, $urandom, $urandom, 1'b1);
        done_items++;
      end
    end
  endtask

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < out_gap_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    ppm_result_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (ppm_results_due.size() == 0) begin
        flag_result("result arrived with none outstanding");
      end else begin
        due = ppm_results_due.pop_front();
        if (out_result_kind !== due.rkind)
          flag_result($sformatf("result_kind %0d, predicted %0d", out_result_kind, due.rkind));
        if (out_channel_index !== due.idx)
          flag_result($sformatf("channel_index %0d, predicted %0d", out_channel_index, due.idx));
        if (out_channel_value !== due.val)
          flag_result($sformatf("channel_value %0d, predicted %0d", out_channel_value, due.val));
        if (out_channel_count !== due.cnt)
          flag_result($sformatf("channel_count %0d, predicted %0d", out_channel_count, due.cnt));
        if (out_last !== due.last)
          flag_result($sformatf("last %0d, predicted %0d", out_last, due.last));
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no request moving anywhere.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows [24];
    reg_set_t  blk_regs [NUM_BLOCKS];
    stim_row_t row;
    int        r;
    int        blk;

    in_valid       <= 1'b0;
    in_kind        <= KIND_EDGE;
    in_interval_us <= '0;
    in_now_us      <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    rst_n          <= 1'b0;

    sync_thr_q  = SYNC_THRESHOLD_RST;
    min_pulse_q = MIN_PULSE_RST;
    max_pulse_q = MAX_PULSE_RST;
    loss_tmo_q  = LOSS_TIMEOUT_RST;
    min_chan_q  = MIN_CHANNELS_RST;
    frame_open  = 1'b0;
    run_count   = '0;
    held_count  = '0;
    sync_stamp  = '0;
    lost_flag   = 1'b0;
    foreach (chan_buf[i]) chan_buf[i] = '0;
    clock_us    = FIRST_STAMP;

    // Directed frames under reset settings: boundaries, empty frames, loss and restore.
    dir_rows = '{
      '{KIND_POLL, 32'd0,          32'd0,          NO_RESULT,  NO_RES},
      '{KIND_EDGE, 32'd1500,       32'd100,        NO_RESULT,  NO_RES},
      '{KIND_EDGE, 32'd0,          32'd200,        NO_RESULT,  NO_RES},
      '{KIND_EDGE, 32'd3991,       32'd1000,       NO_RESULT,  NO_RES},
      '{KIND_EDGE, 32'd901,        32'd2000,       BY_DECODER, NO_RES},
      '{KIND_EDGE, 32'd2099,       32'd3000,       BY_DECODER, NO_RES},
      '{KIND_EDGE, 32'd3991,       32'd5000,       BY_DECODER, NO_RES},
      '{KIND_EDGE, 32'd1500,       32'd6000,       BY_DECODER, NO_RES},
      '{KIND_EDGE, 32'd3990,       32'd7000,       NO_RESULT,  NO_RES},
      '{KIND_EDGE, 32'hFFFF_FFFF,  32'd8000,       NO_RESULT,  NO_RES},
      '{KIND_EDGE, 32'd1000,       32'd9000,       BY_DECODER, NO_RES},
      '{KIND_EDGE, 32'd4000,       32'd10000,      ONE_RESULT,
        '{RK_CHANNEL, 4'd0, 12'd1000, 5'd1, 1'b1}},
      '{KIND_POLL, 32'hFFFF_FFFF,  32'd70001,      ONE_RESULT,
        '{RK_LOST, 4'd0, 12'd0, 5'd0, 1'b1}},
      '{KIND_POLL, 32'd0,          32'hFFFF_FFFF,  NO_RESULT,  NO_RES},
      '{KIND_EDGE, 32'd1200,       32'd71000,      BY_DECODER, NO_RES},
      '{KIND_EDGE, 32'd1300,       32'd72000,      BY_DECODER, NO_RES},
      '{KIND_EDGE, 32'd1400,       32'd73000,      BY_DECODER, NO_RES},
      '{KIND_EDGE, 32'd1500,       32'd74000,      BY_DECODER, NO_RES},
      '{KIND_EDGE, 32'd20000,      32'd80000,      BY_DECODER, NO_RES},
      '{KIND_POLL, 32'd0,          32'd80010,      ONE_RESULT,
        '{RK_RESTORED, 4'd0, 12'd0, 5'd4, 1'b1}},
      '{KIND_POLL, 32'd0,          32'd80020,      NO_RESULT,  NO_RES},
      // Timestamp one below the sync time: elapsed time wraps to the maximum.
      '{KIND_POLL, 32'd0,          32'd79999,      ONE_RESULT,
        '{RK_LOST, 4'd0, 12'd0, 5'd0, 1'b1}},
      '{KIND_EDGE, 32'd3991,       32'd81000,      NO_RESULT,  NO_RES},
      '{KIND_EDGE, 32'd900,        32'd82000,      NO_RESULT,  NO_RES}
    };

    // Register settings per random block; the first keeps the reset values.
    blk_regs = '{
      '{SYNC_THRESHOLD_RST, MIN_PULSE_RST, MAX_PULSE_RST, LOSS_TIMEOUT_RST, MIN_CHANNELS_RST},
      '{16'hFFFF, 16'd0,    16'hFFFF, 32'hFFFF_FFFF, 5'd16},
      '{16'd0,    16'hFFFF, 16'd0,    32'd0,         5'd0},
      '{16'd5000, 16'd1000, 16'd2000, 32'd30000,     5'd31},
      '{16'd4500, 16'd950,  16'd2050, 32'd45000,     5'd8},
      '{16'd3000, 16'd800,  16'd2200, 32'd20000,     5'd1}
    };

    in_gap_pct  = 7;
    out_gap_pct = 61;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: typed rows queue their own result, the rest use the decoder.
    for (r = 0; r < $size(dir_rows); r++) begin
      row = dir_rows[r];
      offer_request(row.kind, row.ivl, row.now, row.check == BY_DECODER);
      if (row.check == ONE_RESULT) ppm_results_due.push_back(row.res);
    end

    // Random blocks: sender-light idling first, then receiver-light, then none.
    for (blk = 0; blk < NUM_BLOCKS; blk++) begin
      if (blk > 0) begin
        wait_idle();
        program_regs(blk_regs[blk]);
      end
      case (blk / 2)
        0: begin in_gap_pct = 7;  out_gap_pct = 61; end
        1: begin in_gap_pct = 61; out_gap_pct = 7;  end
        default: begin in_gap_pct = 0; out_gap_pct = 0; end
      endcase
      if (blk == PRESSURE_BLOCK) hold_pending = 1'b1;
      run_random_block(BLOCK_ITEMS);
    end

    wait_idle();
    if (bad_fields == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ppmd_pkg.sv
rtl/core/ppmd_ctrl.sv
rtl/core/ppmd_dpath.sv
rtl/core/ppm_frame_decoder.sv
rtl/core/ppmd_chk.sv
sim/tb.sv
